// ===== src/bpl_pkg.sv =====
// Package for the Bezier profile lookup block: widths, commands, state codes.
// Used by the table and by the top-level lookup module.
`default_nettype none
package bpl_pkg;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned NumRegs = 8;
    localparam int unsigned RegIdxWidth = 3;

    typedef enum logic
    {
        CMD_BUILD = 1'b0,
        CMD_QUERY = 1'b1
    } command_t;

    typedef enum logic [2:0]
    {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } reg_index_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_BUILD,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHECK_MID,
        ST_RD_HI,
        ST_DIV,
        ST_MUL,
        ST_MUL2,
        ST_RESULT
    } state_t;

    typedef struct packed
    {
        logic [DataWidth-1:0] radius;
        logic clamped;
        logic not_built;
    } result_t;
endpackage
`default_nettype wire

// ===== src/bpl_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface bpl_req_if;
    logic valid;
    logic ready;
    logic command;
    logic signed [31:0] query_x;
    modport source (output valid, command, query_x, input ready);
    modport sink (input valid, command, query_x, output ready);
endinterface

interface bpl_res_if;
    logic valid;
    logic ready;
    logic signed [31:0] radius;
    logic clamped;
    logic not_built;
    modport source (output valid, radius, clamped, not_built, input ready);
    modport sink (input valid, radius, clamped, not_built, output ready);
endinterface
`default_nettype wire

// ===== src/bpl_table.sv =====
// Two synchronous memories holding the sampled curve points, one read port each.
// Depends on bpl_pkg.
`default_nettype none
module bpl_table #(
    parameter int unsigned NUM_POINTS = 128,
    parameter int unsigned AW = 7
) (
    input  wire logic clk,
    input  wire logic wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [bpl_pkg::DataWidth-1:0] wr_x,
    input  wire logic [bpl_pkg::DataWidth-1:0] wr_y,
    input  wire logic [AW-1:0] rd_addr,
    output logic [bpl_pkg::DataWidth-1:0] rd_x,
    output logic [bpl_pkg::DataWidth-1:0] rd_y
);
    logic [bpl_pkg::DataWidth-1:0] mem_x [NUM_POINTS];
    logic [bpl_pkg::DataWidth-1:0] mem_y [NUM_POINTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end
endmodule
`default_nettype wire

// ===== src/bpl_sampler.sv =====
// Sequential de Casteljau sampler: one lerp per cycle, six lerps per axis.
`default_nettype none
module bpl_sampler #(
    parameter int unsigned NUM_POINTS = 128,
    parameter int unsigned AW = 7
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [AW-1:0] index,
    input  wire logic signed [31:0] px [4],
    input  wire logic signed [31:0] py [4],
    output logic done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);
    localparam int unsigned LOG_N = $clog2(NUM_POINTS);
    localparam bit IS_POW2 = ((1 << LOG_N) == NUM_POINTS);
    localparam int unsigned RECIP_SH = 48;
    localparam logic [63:0] RECIP = 64'((65'd1 << RECIP_SH) / NUM_POINTS + 1);

    logic signed [31:0] cx_reg [4];
    logic signed [31:0] cy_reg [4];
    logic [2:0] step_reg;
    logic busy_reg;
    logic signed [32+AW:0] dx_prod;
    logic signed [32+AW:0] dy_prod;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic [1:0] k;

    function automatic logic signed [31:0] fdiv(input logic signed [32+AW:0] p);
        logic signed [32+AW+64:0] wide;
        logic signed [32+AW:0] q;
        begin
            wide = '0;
            q = '0;
            if (IS_POW2)
            begin
                q = p >>> LOG_N;
            end
            else
            begin
                wide = (96+AW+1)'(p) * $signed({1'b0, RECIP});
                q = (32+AW+1)'(wide >>> RECIP_SH);
                if ((33+AW)'(q * $signed((33+AW)'(NUM_POINTS))) > p)
                begin
                    q = q - 1'b1;
                end
                else if ((33+AW)'((q + 2'sd1) * $signed((33+AW)'(NUM_POINTS))) <= p)
                begin
                    q = q + 2'sd1;
                end
            end
            fdiv = q[31:0];
        end
    endfunction

    always_comb
    begin
        unique case (step_reg)
            3'd0, 3'd3, 3'd5: k = 2'd0;
            3'd1, 3'd4: k = 2'd1;
            default: k = 2'd2;
        endcase
        dx_prod = (33+AW)'(33'(cx_reg[k+2'd1]) - 33'(cx_reg[k])) * $signed({1'b0, index});
        dy_prod = (33+AW)'(33'(cy_reg[k+2'd1]) - 33'(cy_reg[k])) * $signed({1'b0, index});
        lx = cx_reg[k] + fdiv(dx_prod);
        ly = cy_reg[k] + fdiv(dy_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg <= px;
            cy_reg <= py;
        end
        else if (busy_reg)
        begin
            cx_reg[k] <= lx;
            cy_reg[k] <= ly;
        end
    end

    assign out_x = cx_reg[0];
    assign out_y = cy_reg[0];
endmodule
`default_nettype wire

// ===== src/bpl_divider.sv =====
// Restoring divider for the interpolation weight, one quotient bit per cycle.
`default_nettype none
module bpl_divider #(
    parameter int unsigned NW = 49,
    parameter int unsigned DW = 33
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic done,
    output logic [NW-1:0] quo
);
    localparam int unsigned CW = $clog2(NW+1);
    logic [DW:0] rem_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic [DW:0] trial;
    logic [DW:0] sub;

    always_comb
    begin
        trial = {rem_reg[DW-1:0], q_reg[NW-1]};
        sub = trial - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg <= num;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!sub[DW])
            begin
                rem_reg <= sub;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg;
endmodule
`default_nettype wire

// ===== src/bezier_profile_lookup.sv =====
// Bezier profile lookup: a build samples each point in turn (sampler start, six serial lerps,
// table write) and then returns its result.
// A query returns not_built without reading the table when no table is built, returns after
// reading both end points on an end point or out of range, stops at probe p on an exact hit,
// and otherwise runs P search probes (at most log2(NUM_POINTS)), the divider and a multiply.
// One request at a time; reset clears control, control points and the built flag only.
`default_nettype none
module bezier_profile_lookup #(
    parameter int unsigned NUM_POINTS = 128,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [bpl_pkg::RegIdxWidth-1:0] cfg_index,
    input  wire logic [bpl_pkg::DataWidth-1:0] cfg_data,
    bpl_req_if.sink req,
    bpl_res_if.source res
);
    localparam int unsigned AW = $clog2(NUM_POINTS);
    localparam int unsigned NW = 33 + FRAC_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_POINTS - 1);

    logic signed [31:0] regs_reg [bpl_pkg::NumRegs];
    logic signed [31:0] px [4];
    logic signed [31:0] py [4];
    bpl_pkg::state_t state_reg, state_next;
    logic built_reg, built_next;
    logic res_valid_reg, res_valid_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0] mid, mid_next;
    logic signed [31:0] q_reg;
    logic signed [31:0] xlo_reg, ylo_reg;
    logic signed [32:0] dy_reg;
    logic [FRAC_BITS-1:0] wq_reg;
    logic signed [FRAC_BITS+33:0] prod_reg;
    bpl_pkg::result_t res_reg;
    logic [AW-1:0] rd_addr;
    logic signed [31:0] rd_x, rd_y;
    logic samp_start, samp_done;
    logic signed [31:0] sx, sy;
    logic div_start, div_done;
    logic signed [32:0] dx_num, dx_den;
    logic [NW-1:0] div_num;
    logic [NW-1:0] quo;
    logic req_fire;

    for (genvar g = 0; g < 4; g++)
    begin : g_ctrl
        assign px[g] = regs_reg[2*g];
        assign py[g] = regs_reg[2*g+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(bpl_pkg::NumRegs); i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    assign mid = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign dx_num = 33'(q_reg) - 33'(xlo_reg);
    assign dx_den = 33'(rd_x) - 33'(xlo_reg);
    assign div_num = {1'b0, dx_num[31:0], {FRAC_BITS{1'b0}}};

    bpl_sampler #(.NUM_POINTS(NUM_POINTS), .AW(AW)) u_sampler (
        .clk(clk), .rst_n(rst_n), .start(samp_start), .index(idx_reg),
        .px(px), .py(py), .done(samp_done), .out_x(sx), .out_y(sy)
    );

    bpl_table #(.NUM_POINTS(NUM_POINTS), .AW(AW)) u_table (
        .clk(clk), .wr_en(samp_done), .wr_addr(idx_reg), .wr_x(sx), .wr_y(sy),
        .rd_addr(rd_addr), .rd_x(rd_x), .rd_y(rd_y)
    );

    bpl_divider #(.NW(NW), .DW(33)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den(dx_den),
        .done(div_done), .quo(quo)
    );

    assign req.ready = (state_reg == bpl_pkg::ST_IDLE) && !res_valid_reg;
    assign req_fire = req.valid && req.ready;
    assign res.valid = res_valid_reg;
    assign res.radius = res_reg.radius;
    assign res.clamped = res_reg.clamped;
    assign res.not_built = res_reg.not_built;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid;
        built_next = built_reg;
        samp_start = 1'b0;
        div_start = 1'b0;
        rd_addr = '0;
        res_valid_next = res_valid_reg;
        if (state_reg == bpl_pkg::ST_RESULT)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            bpl_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.command == bpl_pkg::CMD_BUILD)
                    begin
                        idx_next = '0;
                        samp_start = 1'b1;
                        state_next = bpl_pkg::ST_BUILD;
                    end
                    else if (built_reg)
                    begin
                        rd_addr = '0;
                        lo_next = '0;
                        hi_next = LAST_IDX;
                        state_next = bpl_pkg::ST_RD_FIRST;
                    end
                    else
                    begin
                        state_next = bpl_pkg::ST_RESULT;
                    end
                end
            end
            bpl_pkg::ST_BUILD:
            begin
                if (samp_done)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        built_next = 1'b1;
                        state_next = bpl_pkg::ST_RESULT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        samp_start = 1'b1;
                    end
                end
            end
            bpl_pkg::ST_RD_FIRST:
            begin
                rd_addr = LAST_IDX;
                state_next = bpl_pkg::ST_RD_LAST;
            end
            bpl_pkg::ST_RD_LAST:
            begin
                if (q_reg == xlo_reg || q_reg == rd_x || q_reg < xlo_reg || q_reg > rd_x)
                begin
                    state_next = bpl_pkg::ST_RESULT;
                end
                else
                begin
                    rd_addr = mid;
                    state_next = bpl_pkg::ST_CHECK_MID;
                end
            end
            bpl_pkg::ST_CHECK_MID:
            begin
                if (rd_x == q_reg)
                begin
                    state_next = bpl_pkg::ST_RESULT;
                end
                else
                begin
                    if (rd_x < q_reg)
                    begin
                        lo_next = mid;
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                    mid_next = AW'(({1'b0, lo_next} + {1'b0, hi_next}) >> 1);
                    if (AW'(hi_next - lo_next) > AW'(1))
                    begin
                        rd_addr = mid_next;
                    end
                    else
                    begin
                        rd_addr = hi_next;
                        state_next = bpl_pkg::ST_RD_HI;
                    end
                end
            end
            bpl_pkg::ST_RD_HI:
            begin
                div_start = 1'b1;
                state_next = bpl_pkg::ST_DIV;
            end
            bpl_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = bpl_pkg::ST_MUL;
                end
            end
            bpl_pkg::ST_MUL:
            begin
                state_next = bpl_pkg::ST_MUL2;
            end
            bpl_pkg::ST_MUL2:
            begin
                state_next = bpl_pkg::ST_RESULT;
            end
            bpl_pkg::ST_RESULT:
            begin
                state_next = bpl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bpl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpl_pkg::ST_IDLE;
            built_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            idx_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            res_valid_reg <= res_valid_next;
            idx_reg <= idx_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bpl_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    q_reg <= req.query_x;
                    res_reg <= {{bpl_pkg::DataWidth{1'b0}}, 1'b0,
                                (req.command == bpl_pkg::CMD_QUERY) && !built_reg};
                end
            end
            bpl_pkg::ST_RD_FIRST:
            begin
                xlo_reg <= rd_x;
                ylo_reg <= rd_y;
            end
            bpl_pkg::ST_RD_LAST:
            begin
                if (q_reg == xlo_reg)
                begin
                    res_reg <= {ylo_reg, 1'b0, 1'b0};
                end
                else if (q_reg == rd_x)
                begin
                    res_reg <= {rd_y, 1'b0, 1'b0};
                end
                else if (q_reg < xlo_reg)
                begin
                    res_reg <= {ylo_reg, 1'b1, 1'b0};
                end
                else if (q_reg > rd_x)
                begin
                    res_reg <= {rd_y, 1'b1, 1'b0};
                end
            end
            bpl_pkg::ST_CHECK_MID:
            begin
                if (rd_x == q_reg)
                begin
                    res_reg <= {rd_y, 1'b0, 1'b0};
                end
                else if (rd_x < q_reg)
                begin
                    xlo_reg <= rd_x;
                    ylo_reg <= rd_y;
                end
            end
            bpl_pkg::ST_RD_HI:
            begin
                dy_reg <= 33'(rd_y) - 33'(ylo_reg);
            end
            bpl_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    wq_reg <= quo[FRAC_BITS-1:0];
                end
            end
            bpl_pkg::ST_MUL:
            begin
                prod_reg <= $signed({1'b0, wq_reg}) * dy_reg;
            end
            bpl_pkg::ST_MUL2:
            begin
                res_reg <= {ylo_reg + 32'(prod_reg >>> FRAC_BITS), 1'b0, 1'b0};
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire
